// ===== src/dpkd_pkg.sv =====
package dpkd_pkg;

	localparam int NUM_KEYS_DEF = 16;
	localparam int KEY_W = 4;
	localparam int SIG_W = 2;
	localparam int STABLE_W = 8;
	localparam int STUCK_W = 16;

	localparam logic [STABLE_W-1:0] STABLE_RESET = 8'd2;
	localparam logic [STUCK_W-1:0] STUCK_RESET = 16'd250;

	typedef enum logic [1:0] {
		EV_NONE = 2'd0,
		EV_PRESS = 2'd1,
		EV_RELEASE = 2'd2,
		EV_RELEARN = 2'd3
	} event_t;

	typedef enum logic {
		CMD_SAMPLE = 1'b0,
		CMD_CALIBRATE = 1'b1
	} command_t;

	typedef enum logic {
		CFG_STABLE = 1'b0,
		CFG_STUCK = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [SIG_W-1:0] rest_sig;
		logic [SIG_W-1:0] partial_sig;
		logic [SIG_W-1:0] prev_sig;
		logic [STABLE_W-1:0] match_cnt;
		logic pressed;
		logic [STUCK_W-1:0] held_cnt;
	} key_state_t;

	typedef struct packed {
		logic command;
		logic [KEY_W-1:0] key;
		logic phase;
		logic level;
		logic [SIG_W-1:0] base_sig;
	} item_t;

	typedef struct packed {
		event_t ev;
		logic [SIG_W-1:0] settled;
	} result_t;

endpackage

// ===== src/dual_pull_key_debouncer.sv =====
// Dual-pull key debouncer for a bank of keys.
// Item channel (item_valid/item_stall): one beat per pin sample or calibrate
// command, fields command, key_index, phase, level, baseline_signature.
// Result channel (res_valid/res_stall): exactly one beat per item, carrying
// event_res, event_key and settled_signature, in item order.
// Config channel (cfg_valid/cfg_ready): cfg_index 0 writes stable_cycles,
// 1 writes stuck_limit from cfg_data; cfg_ready is always high. Write only
// while no item is in flight.
// An item is registered into the update stage, and its result into the
// output stage that drives res_valid and the result fields.
// Throughput: one item per cycle while results are not stalled. Per-key
// state is read from a memory when an item is taken and written back
// when it leaves the update stage; a write to the key being read is
// forwarded, so back-to-back items on one key see each other's updates.
// Reset: all keys read as zero state (per-key written flags), registers
// return to stable_cycles 2 and stuck_limit 250; no clearing pass.
// Stall: a stalled result holds; one more item is taken into the update
// stage, then item_stall rises until the result is taken.
module dual_pull_key_debouncer #(
	parameter int NUM_KEYS = dpkd_pkg::NUM_KEYS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input logic command,
	input logic [dpkd_pkg::KEY_W-1:0] key_index,
	input logic phase,
	input logic level,
	input logic [dpkd_pkg::SIG_W-1:0] baseline_signature,
	output logic res_valid,
	input logic res_stall,
	output logic [1:0] event_res,
	output logic [dpkd_pkg::KEY_W-1:0] event_key,
	output logic [dpkd_pkg::SIG_W-1:0] settled_signature,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_index,
	input logic [dpkd_pkg::STUCK_W-1:0] cfg_data
);

	localparam int IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
	localparam int EXT_W = (IDX_W > dpkd_pkg::KEY_W) ? IDX_W : dpkd_pkg::KEY_W;

	logic [dpkd_pkg::STABLE_W-1:0] stable_q;
	logic [dpkd_pkg::STUCK_W-1:0] stuck_q;

	logic accept;
	logic move;
	logic in_range;
	logic hit;
	logic [EXT_W-1:0] key_ext;
	logic [EXT_W-1:0] key_ext_s1;
	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] wr_addr;

	logic vld_s1;
	dpkd_pkg::item_t item_s1;
	logic in_range_s1;
	logic fwd_s1;
	dpkd_pkg::key_state_t fwd_data_s1;
	dpkd_pkg::key_state_t rd_data;
	logic rd_written;
	dpkd_pkg::key_state_t cur;
	dpkd_pkg::key_state_t nxt;
	dpkd_pkg::result_t res;

	logic vld_s2;
	dpkd_pkg::result_t res_s2;
	logic [dpkd_pkg::KEY_W-1:0] key_s2;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q <= dpkd_pkg::STABLE_RESET;
			stuck_q <= dpkd_pkg::STUCK_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				dpkd_pkg::CFG_STABLE: stable_q <= cfg_data[dpkd_pkg::STABLE_W-1:0];
				dpkd_pkg::CFG_STUCK: stuck_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign move = vld_s1 && (!vld_s2 || !res_stall);
	assign item_stall = vld_s1 && !move;
	assign accept = item_valid && !item_stall;

	assign in_range = 32'(key_index) < NUM_KEYS;
	assign key_ext = EXT_W'(key_index);
	assign key_ext_s1 = EXT_W'(item_s1.key);
	assign rd_addr = key_ext[IDX_W-1:0];
	assign wr_addr = key_ext_s1[IDX_W-1:0];
	assign hit = move && in_range_s1 && (item_s1.key == key_index);

	dpkd_state_mem #(
		.NUM_KEYS(NUM_KEYS)
	) u_mem (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(accept),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.rd_written(rd_written),
		.wr_en(move && in_range_s1),
		.wr_addr(wr_addr),
		.wr_data(nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (move) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= '{command: command, key: key_index, phase: phase, level: level,
				base_sig: baseline_signature};
			in_range_s1 <= in_range;
			fwd_s1 <= hit;
			fwd_data_s1 <= nxt;
		end
	end

	always_comb begin
		if (fwd_s1) begin
			cur = fwd_data_s1;
		end else if (rd_written) begin
			cur = rd_data;
		end else begin
			cur = '0;
		end
	end

	dpkd_update u_update (
		.item(item_s1),
		.in_range(in_range_s1),
		.cur(cur),
		.stable_cycles(stable_q),
		.stuck_limit(stuck_q),
		.nxt(nxt),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (move) begin
			vld_s2 <= 1'b1;
		end else if (!res_stall) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			res_s2 <= res;
			key_s2 <= item_s1.key;
		end
	end

	assign res_valid = vld_s2;
	assign event_res = res_s2.ev;
	assign event_key = key_s2;
	assign settled_signature = res_s2.settled;

endmodule

// ===== src/dpkd_state_mem.sv =====
module dpkd_state_mem #(
	parameter int NUM_KEYS = dpkd_pkg::NUM_KEYS_DEF,
	localparam int IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1
) (
	input logic clk,
	input logic arst_n,
	input logic rd_en,
	input logic [IDX_W-1:0] rd_addr,
	output dpkd_pkg::key_state_t rd_data,
	output logic rd_written,
	input logic wr_en,
	input logic [IDX_W-1:0] wr_addr,
	input dpkd_pkg::key_state_t wr_data
);

	dpkd_pkg::key_state_t mem [NUM_KEYS];
	logic [NUM_KEYS-1:0] written_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			rd_written <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_written <= written_q[rd_addr];
			end
		end
	end

endmodule

// ===== src/dpkd_update.sv =====
module dpkd_update (
	input dpkd_pkg::item_t item,
	input logic in_range,
	input dpkd_pkg::key_state_t cur,
	input logic [dpkd_pkg::STABLE_W-1:0] stable_cycles,
	input logic [dpkd_pkg::STUCK_W-1:0] stuck_limit,
	output dpkd_pkg::key_state_t nxt,
	output dpkd_pkg::result_t res
);

	logic [dpkd_pkg::SIG_W-1:0] sig;
	logic now_pressed;
	logic [dpkd_pkg::STUCK_W-1:0] held_inc;

	always_comb begin
		sig = cur.partial_sig | {1'b0, item.level};
		now_pressed = (sig != cur.rest_sig);
		held_inc = cur.held_cnt + 16'd1;
		nxt = cur;
		res.ev = dpkd_pkg::EV_NONE;
		if (item.command == dpkd_pkg::CMD_CALIBRATE) begin
			nxt.rest_sig = item.base_sig;
			nxt.partial_sig = item.base_sig;
			nxt.prev_sig = item.base_sig;
			nxt.match_cnt = stable_cycles;
			nxt.pressed = 1'b0;
			nxt.held_cnt = '0;
		end else if (!item.phase) begin
			nxt.partial_sig = {item.level, 1'b0};
		end else begin
			nxt.partial_sig = sig;
			if (sig != cur.prev_sig) begin
				nxt.prev_sig = sig;
				nxt.match_cnt = 8'd1;
			end else if (cur.match_cnt < stable_cycles) begin
				nxt.match_cnt = cur.match_cnt + 8'd1;
			end else if (now_pressed != cur.pressed) begin
				nxt.pressed = now_pressed;
				nxt.held_cnt = '0;
				res.ev = now_pressed ? dpkd_pkg::EV_PRESS : dpkd_pkg::EV_RELEASE;
			end else if (now_pressed) begin
				nxt.held_cnt = held_inc;
				if (held_inc > stuck_limit) begin
					nxt.rest_sig = sig;
					nxt.pressed = 1'b0;
					nxt.held_cnt = '0;
					res.ev = dpkd_pkg::EV_RELEARN;
				end
			end
		end
		res.settled = nxt.prev_sig;
		if (!in_range) begin
			res.ev = dpkd_pkg::EV_NONE;
			res.settled = '0;
		end
	end

endmodule

// ===== dv/dual_pull_key_debouncer_tb.sv =====
`timescale 1ns / 1ps

module dual_pull_key_debouncer_tb;

	localparam int WATCH_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int DIR_ROWS = 23;

	typedef struct packed {
		dpkd_pkg::event_t ev;
		logic [dpkd_pkg::KEY_W-1:0] key;
		logic [dpkd_pkg::SIG_W-1:0] sig;
	} key_event_t;

	typedef struct packed {
		dpkd_pkg::command_t cmd;
		logic [dpkd_pkg::KEY_W-1:0] key;
		logic ph;
		logic lv;
		logic [dpkd_pkg::SIG_W-1:0] base;
		logic typed;
		dpkd_pkg::event_t ev;
		logic [dpkd_pkg::SIG_W-1:0] sig;
	} dir_row_t;

	localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
		'{dpkd_pkg::CMD_SAMPLE, 4'd0, 1'b0, 1'b0, 2'd3, 1'b1, dpkd_pkg::EV_NONE, 2'd0},
		'{dpkd_pkg::CMD_SAMPLE, 4'd0, 1'b1, 1'b0, 2'd3, 1'b1, dpkd_pkg::EV_NONE, 2'd0},
		'{dpkd_pkg::CMD_SAMPLE, 4'd0, 1'b0, 1'b1, 2'd0, 1'b1, dpkd_pkg::EV_NONE, 2'd0},
		'{dpkd_pkg::CMD_SAMPLE, 4'd0, 1'b1, 1'b1, 2'd0, 1'b0, dpkd_pkg::EV_NONE, 2'd0},
		'{dpkd_pkg::CMD_SAMPLE, 4'd0, 1'b0, 1'b1, 2'd1, 1'b0, dpkd_pkg::EV_NONE, 2'd0},
		'{dpkd_pkg::CMD_SAMPLE, 4'd0, 1'b1, 1'b1, 2'd2, 1'b0, dpkd_pkg::EV_NONE, 2'd0},
		'{dpkd_pkg::CMD_SAMPLE, 4'd0, 1'b0, 1'b1, 2'd0, 1'b0, dpkd_pkg::EV_NONE, 2'd0},
		'{dpkd_pkg::CMD_SAMPLE, 4'd0, 1'b1, 1'b1, 2'd3, 1'b0, dpkd_pkg::EV_NONE, 2'd0},
		'{dpkd_pkg::CMD_SAMPLE, 4'd0, 1'b0, 1'b0, 2'd0, 1'b0, dpkd_pkg::EV_NONE, 2'd0},
		'{dpkd_pkg::CMD_SAMPLE, 4'd0, 1'b1, 1'b0, 2'd1, 1'b0, dpkd_pkg::EV_NONE, 2'd0},
		'{dpkd_pkg::CMD_SAMPLE, 4'd0, 1'b0, 1'b0, 2'd2, 1'b0, dpkd_pkg::EV_NONE, 2'd0},
		'{dpkd_pkg::CMD_SAMPLE, 4'd0, 1'b1, 1'b0, 2'd3, 1'b0, dpkd_pkg::EV_NONE, 2'd0},
		'{dpkd_pkg::CMD_SAMPLE, 4'd0, 1'b0, 1'b0, 2'd0, 1'b0, dpkd_pkg::EV_NONE, 2'd0},
		'{dpkd_pkg::CMD_SAMPLE, 4'd0, 1'b1, 1'b0, 2'd0, 1'b0, dpkd_pkg::EV_NONE, 2'd0},
		'{dpkd_pkg::CMD_CALIBRATE, 4'd15, 1'b0, 1'b0, 2'd3, 1'b1, dpkd_pkg::EV_NONE, 2'd3},
		'{dpkd_pkg::CMD_SAMPLE, 4'd15, 1'b0, 1'b1, 2'd0, 1'b1, dpkd_pkg::EV_NONE, 2'd3},
		'{dpkd_pkg::CMD_CALIBRATE, 4'd15, 1'b1, 1'b1, 2'd0, 1'b1, dpkd_pkg::EV_NONE, 2'd0},
		'{dpkd_pkg::CMD_SAMPLE, 4'd7, 1'b1, 1'b1, 2'd0, 1'b0, dpkd_pkg::EV_NONE, 2'd0},
		'{dpkd_pkg::CMD_SAMPLE, 4'd7, 1'b1, 1'b0, 2'd0, 1'b0, dpkd_pkg::EV_NONE, 2'd0},
		'{dpkd_pkg::CMD_SAMPLE, 4'd10, 1'b0, 1'b1, 2'd1, 1'b0, dpkd_pkg::EV_NONE, 2'd0},
		'{dpkd_pkg::CMD_SAMPLE, 4'd5, 1'b1, 1'b1, 2'd2, 1'b0, dpkd_pkg::EV_NONE, 2'd0},
		'{dpkd_pkg::CMD_CALIBRATE, 4'd10, 1'b0, 1'b0, 2'd2, 1'b1, dpkd_pkg::EV_NONE, 2'd2},
		'{dpkd_pkg::CMD_SAMPLE, 4'd10, 1'b1, 1'b1, 2'd0, 1'b0, dpkd_pkg::EV_NONE, 2'd0}
	};

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	logic command;
	logic [dpkd_pkg::KEY_W-1:0] key_index;
	logic phase;
	logic level;
	logic [dpkd_pkg::SIG_W-1:0] baseline_signature;
	logic res_valid;
	logic res_stall = 1'b0;
	logic [1:0] event_res;
	logic [dpkd_pkg::KEY_W-1:0] event_key;
	logic [dpkd_pkg::SIG_W-1:0] settled_signature;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_index;
	logic [dpkd_pkg::STUCK_W-1:0] cfg_data;

	dpkd_pkg::key_state_t key_mem [dpkd_pkg::NUM_KEYS_DEF];
	logic [dpkd_pkg::STABLE_W-1:0] stable_cfg;
	logic [dpkd_pkg::STUCK_W-1:0] stuck_cfg;
	key_event_t pending_events [$];

	int send_pct;
	int recv_pct;
	int errors;
	int items_sent;
	int results_seen;
	int idle_cycles;
	int ev_seen [4];

	dual_pull_key_debouncer u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.command(command),
		.key_index(key_index),
		.phase(phase),
		.level(level),
		.baseline_signature(baseline_signature),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.event_res(event_res),
		.event_key(event_key),
		.settled_signature(settled_signature),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic key_event_t settle_key(input dpkd_pkg::item_t it);
		dpkd_pkg::key_state_t s;
		key_event_t r;
		logic [dpkd_pkg::SIG_W-1:0] sig;
		logic now;
		s = key_mem[it.key];
		r.ev = dpkd_pkg::EV_NONE;
		r.key = it.key;
		if (it.command == dpkd_pkg::CMD_CALIBRATE) begin
			s.rest_sig = it.base_sig;
			s.partial_sig = it.base_sig;
			s.prev_sig = it.base_sig;
			s.match_cnt = stable_cfg;
			s.pressed = 1'b0;
			s.held_cnt = '0;
		end else if (!it.phase) begin
			s.partial_sig = {it.level, 1'b0};
		end else begin
			s.partial_sig = s.partial_sig | {1'b0, it.level};
			sig = s.partial_sig;
			if (sig != s.prev_sig) begin
				s.prev_sig = sig;
				s.match_cnt = 8'd1;
			end else if (s.match_cnt < stable_cfg) begin
				s.match_cnt = s.match_cnt + 8'd1;
			end else begin
				now = (sig != s.rest_sig);
				if (now != s.pressed) begin
					s.pressed = now;
					s.held_cnt = '0;
					r.ev = now ? dpkd_pkg::EV_PRESS : dpkd_pkg::EV_RELEASE;
				end else if (now) begin
					s.held_cnt = s.held_cnt + 16'd1;
					if (s.held_cnt > stuck_cfg) begin
						s.rest_sig = sig;
						s.pressed = 1'b0;
						s.held_cnt = '0;
						r.ev = dpkd_pkg::EV_RELEARN;
					end
				end
			end
		end
		r.sig = s.prev_sig;
		key_mem[it.key] = s;
		return r;
	endfunction

	task automatic send_beat(input dpkd_pkg::item_t it, input logic typed,
		input key_event_t typed_ev);
		int gap;
		key_event_t got;
		gap = 0;
		while ($urandom_range(99) < send_pct)
			gap++;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		command <= it.command;
		key_index <= it.key;
		phase <= it.phase;
		level <= it.level;
		baseline_signature <= it.base_sig;
		do @(posedge clk); while (item_stall);
		got = settle_key(it);
		pending_events.push_back(typed ? typed_ev : got);
		items_sent++;
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (pending_events.size() != 0);
	endtask

	task automatic write_settings(input logic [dpkd_pkg::STABLE_W-1:0] stab,
		input logic [dpkd_pkg::STUCK_W-1:0] stuck);
		cfg_valid <= 1'b1;
		cfg_index <= dpkd_pkg::CFG_STABLE;
		cfg_data <= {8'($urandom), stab};
		do @(posedge clk); while (!cfg_ready);
		stable_cfg = stab;
		cfg_index <= dpkd_pkg::CFG_STUCK;
		cfg_data <= stuck;
		do @(posedge clk); while (!cfg_ready);
		stuck_cfg = stuck;
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input logic [dpkd_pkg::STABLE_W-1:0] stab,
		input logic [dpkd_pkg::STUCK_W-1:0] stuck,
		input int s_pct, input int r_pct, input int klo, input int khi, input int n_items,
		input int chg_pm);
		int sent;
		int k;
		int r;
		bit paused;
		dpkd_pkg::item_t it;
		logic [dpkd_pkg::SIG_W-1:0] tgt [dpkd_pkg::NUM_KEYS_DEF];
		logic [dpkd_pkg::SIG_W-1:0] sig;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		write_settings(stab, stuck);
		send_pct = s_pct;
		recv_pct = r_pct;
		for (k = 0; k < dpkd_pkg::NUM_KEYS_DEF; k++)
			tgt[k] = 2'($urandom_range(3));
		sent = 0;
		paused = 1'b0;
		while (sent < n_items) begin
			if (!paused && sent >= n_items / 2) begin
				// hold off until every result is back
				paused = 1'b1;
				item_valid <= 1'b0;
				wait_drained();
			end
			k = $urandom_range(khi, klo);
			r = $urandom_range(99);
			it.command = dpkd_pkg::CMD_SAMPLE;
			it.key = 4'(k);
			it.base_sig = 2'($urandom_range(3));
			if (r < 70 || r >= 94) begin
				if ($urandom_range(999) < chg_pm)
					tgt[k] = 2'($urandom_range(3));
				sig = tgt[k];
				if (r >= 94 || $urandom_range(99) < 8)
					sig = sig ^ 2'($urandom_range(3));
				it.phase = 1'b0;
				it.level = sig[1];
				send_beat(it, 1'b0, '0);
				it.phase = 1'b1;
				it.level = sig[0];
				it.base_sig = 2'($urandom_range(3));
				send_beat(it, 1'b0, '0);
				sent += 2;
			end else if (r < 88) begin
				it.phase = (r < 80);
				it.level = 1'($urandom_range(1));
				send_beat(it, 1'b0, '0);
				sent++;
			end else begin
				it.command = dpkd_pkg::CMD_CALIBRATE;
				it.phase = 1'($urandom_range(1));
				it.level = 1'($urandom_range(1));
				send_beat(it, 1'b0, '0);
				sent++;
			end
		end
		item_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		key_event_t want;
		if (!arst_n) begin
			res_stall <= 1'b0;
			idle_cycles = 0;
		end else begin
			if (res_valid && !res_stall) begin
				results_seen++;
				ev_seen[event_res]++;
				if (pending_events.size() == 0) begin
					$error("result beat with nothing expected: event_res %0d event_key %0d",
						event_res, event_key);
					errors++;
				end else begin
					want = pending_events.pop_front();
					if (event_res !== want.ev) begin
						$error("event_res: expected %0d, got %0d", want.ev, event_res);
						errors++;
					end
					if (event_key !== want.key) begin
						$error("event_key: expected %0d, got %0d", want.key, event_key);
						errors++;
					end
					if (settled_signature !== want.sig) begin
						$error("settled_signature: expected %0d, got %0d", want.sig,
							settled_signature);
						errors++;
					end
				end
			end
			if ((res_valid && !res_stall) || (item_valid && !item_stall) ||
				(cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCH_LIMIT) begin
				$display("dual_pull_key_debouncer_tb: done, errors");
				$finish;
			end else begin
				res_stall <= ($urandom_range(99) < recv_pct);
			end
		end
	end

	initial begin
		dpkd_pkg::item_t it;
		key_event_t ev;
		int i;
		arst_n = 1'b0;
		item_valid = 1'b0;
		command = 1'b0;
		key_index = '0;
		phase = 1'b0;
		level = 1'b0;
		baseline_signature = '0;
		cfg_valid = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		send_pct = 0;
		recv_pct = 0;
		errors = 0;
		items_sent = 0;
		results_seen = 0;
		for (i = 0; i < 4; i++)
			ev_seen[i] = 0;
		stable_cfg = dpkd_pkg::STABLE_RESET;
		stuck_cfg = dpkd_pkg::STUCK_RESET;
		for (i = 0; i < dpkd_pkg::NUM_KEYS_DEF; i++)
			key_mem[i] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < DIR_ROWS; i++) begin
			it.command = DIR_TABLE[i].cmd;
			it.key = DIR_TABLE[i].key;
			it.phase = DIR_TABLE[i].ph;
			it.level = DIR_TABLE[i].lv;
			it.base_sig = DIR_TABLE[i].base;
			ev.ev = DIR_TABLE[i].ev;
			ev.key = DIR_TABLE[i].key;
			ev.sig = DIR_TABLE[i].sig;
			send_beat(it, DIR_TABLE[i].typed, ev);
		end
		item_valid <= 1'b0;

		run_phase(8'd1, 16'd1, 0, 0, 0, 3, 200, 150);
		run_phase(8'd0, 16'd3, 80, 0, 0, 15, 200, 150);
		run_phase(8'd255, 16'd65535, 0, 80, 9, 9, 600, 3);
		run_phase(8'd3, 16'd65534, 22, 22, 0, 15, 150, 100);
		run_phase(8'($urandom_range(6, 1)), 16'($urandom_range(30, 1)), 0, 0, 0, 15, 150, 120);
		run_phase(8'($urandom_range(6, 1)), 16'($urandom_range(30, 1)), 22, 22, 12, 15, 150,
			120);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d item beats over directed rows and six register settings, %0d results",
			items_sent, results_seen);
		$display("events seen: %0d press, %0d release, %0d idle re-learn",
			ev_seen[dpkd_pkg::EV_PRESS], ev_seen[dpkd_pkg::EV_RELEASE],
			ev_seen[dpkd_pkg::EV_RELEARN]);
		if (errors == 0)
			$display("dual_pull_key_debouncer_tb: done, clean");
		else
			$display("dual_pull_key_debouncer_tb: done, errors");
		$finish;
	end

endmodule
